// ===== hw/rtl/lcsa_pkg.sv =====
// ============================================================================
// lcsa_pkg: shared constants and types of the lab-to-CM angle converter
// Fixed-point constants (Q30), arc tangent table, result status codes.
// ============================================================================
package lcsa_pkg;

    localparam int QF                  = 30;
    localparam int ANGLE_FRAC_BITS_DEF = 15;
    localparam int RATIO_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STAGES_DEF   = 16;

    // Width of the CORDIC datapath (x, y, z), signed
    localparam int CW = 34;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] K_Q30       = 32'd652032874;
    localparam logic [31:0] ONE_Q       = 32'h4000_0000;

    localparam logic [15:0] MASS_RATIO_RST = 16'd4096;
    localparam logic [15:0] CM_ANGLE_MAX   = 16'hFFFF;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
    };

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_NO_ROOT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] cm_angle;
        t_status     status;
        logic        last;
    } t_result;

    // Root flags that travel alongside the larger-root arc cosine pipeline
    typedef struct packed {
        logic neg_disc;
        logic in0;
    } t_root_flags;

endpackage

// ===== hw/rtl/lcsa_if.sv =====
// ============================================================================
// lcsa_if: valid/ready channels of the lab-to-CM angle converter
// Input channel carries one lab angle word, output channel one result word.
// ============================================================================
interface lcsa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] lab_angle;

    modport source (output valid, output lab_angle, input ready);
    modport sink   (input valid, input lab_angle, output ready);
endinterface

interface lcsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cm_angle;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output cm_angle, output status, output last, input ready);
    modport sink   (input valid, input cm_angle, input status, input last, output ready);
endinterface

// ===== hw/rtl/lcsa_sqrt.sv =====
// ============================================================================
// lcsa_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per register stage, with sideband.
// ============================================================================
module lcsa_sqrt #(
    parameter int IW  = 62,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IW-1:0]     i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [IW/2-1:0]   o_root,
    output logic [SBW-1:0]    o_sb
);
    localparam int OW  = IW / 2;
    localparam int RMW = OW + 2;

    logic [RMW-1:0] r_rem  [OW];
    logic [OW-1:0]  r_root [OW];
    logic [IW-1:0]  r_rad  [OW];
    logic [SBW-1:0] r_sb   [OW];
    logic           r_v    [OW];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [RMW-1:0] rem_i;
        logic [OW-1:0]  root_i;
        logic [IW-1:0]  rad_i;
        logic [SBW-1:0] sb_i;
        logic           v_i;
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = i_rad;
            assign sb_i   = i_sb;
            assign v_i    = i_valid;
        end else begin : g_next
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
            assign rad_i  = r_rad[k-1];
            assign sb_i   = r_sb[k-1];
            assign v_i    = r_v[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_t = {rem_i[RMW-3:0], rad_i[IW-1:IW-2]};
        assign trial = {root_i, 2'b01};
        assign ge    = rem_t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? rem_t - trial : rem_t;
                r_root[k] <= {root_i[OW-2:0], ge};
                r_rad[k]  <= rad_i << 2;
                r_sb[k]   <= sb_i;
            end
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_i;
            end
        end
    end

    assign o_valid = r_v[OW-1];
    assign o_root  = r_root[OW-1];
    assign o_sb    = r_sb[OW-1];
endmodule

// ===== hw/rtl/lcsa_cos.sv =====
// ============================================================================
// lcsa_cos: pipelined cosine of the lab angle
// Symmetry reduction, scaling to Q30 radians, rotation-mode CORDIC, clamp.
// ============================================================================
module lcsa_cos import lcsa_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [15:0]        i_lab_angle,
    output logic               o_valid,
    output logic signed [31:0] o_cos
);
    localparam int AW = ANGLE_FRAC_BITS + 1;
    localparam int PW = ANGLE_FRAC_BITS + 33;
    localparam logic [AW:0] FULL_A    = (AW+1)'(1) << AW;
    localparam logic [AW:0] HALF_A    = (AW+1)'(1) << ANGLE_FRAC_BITS;
    localparam logic [AW:0] QUARTER_A = (AW+1)'(1) << (ANGLE_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q);

    logic [AW:0] a_m;
    logic [AW:0] a_h;
    logic [AW:0] a_q;
    logic        neg_q;
    logic [PW-1:0] n_prod;

    logic [ANGLE_FRAC_BITS-1:0] r_a;
    logic                       r_neg_a;
    logic                       r_v_a;

    logic signed [CW-1:0] r_x   [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y   [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_z   [CORDIC_STAGES+1];
    logic                 r_neg [CORDIC_STAGES+1];
    logic                 r_v   [CORDIC_STAGES+1];

    logic signed [31:0] r_cos;
    logic               r_v_o;
    logic signed [CW-1:0] x_cl;

    // fold onto [0, pi/2], remember the sign flip
    always_comb begin
        a_m   = (AW+1)'(AW'(i_lab_angle));
        a_h   = (a_m > HALF_A) ? FULL_A - a_m : a_m;
        neg_q = a_h > QUARTER_A;
        a_q   = neg_q ? HALF_A - a_h : a_h;
    end

    assign n_prod = PW'(r_a) * PW'(PI_Q30) + PW'(QUARTER_A);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= a_q[ANGLE_FRAC_BITS-1:0];
            r_neg_a <= neg_q;
            r_x[0]  <= CW'(K_Q30);
            r_y[0]  <= '0;
            r_z[0]  <= CW'(n_prod >> ANGLE_FRAC_BITS);
            r_neg[0] <= r_neg_a;
        end
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v_a <= i_valid;
            r_v[0] <= r_v_a;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        localparam logic signed [CW-1:0] AT = CW'(ATAN_Q30[i]);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - AT;
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + AT;
                end
                r_neg[i+1] <= r_neg[i];
            end
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    // clamp to [0, 1] and restore the sign
    always_comb begin
        x_cl = r_x[CORDIC_STAGES];
        if (x_cl < 0) begin
            x_cl = '0;
        end else if (x_cl > ONE_C) begin
            x_cl = ONE_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[CORDIC_STAGES] ? -x_cl[31:0] : x_cl[31:0];
        end
        if (!i_rst_n) begin
            r_v_o <= 1'b0;
        end else if (i_en) begin
            r_v_o <= r_v[CORDIC_STAGES];
        end
    end

    assign o_valid = r_v_o;
    assign o_cos   = r_cos;
endmodule

// ===== hw/rtl/lcsa_quad.sv =====
// ============================================================================
// lcsa_quad: pipelined quadratic solver for cos of the CM angle
// Forms the coefficients, the discriminant, its root and both candidates.
// ============================================================================
module lcsa_quad import lcsa_pkg::*; #(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_cos,
    input  logic [15:0]        i_mass_ratio,
    output logic               o_valid,
    output logic               o_neg_disc,
    output logic               o_in0,
    output logic               o_in1,
    output logic signed [31:0] o_x0,
    output logic signed [31:0] o_x1
);
    localparam int R     = RATIO_FRAC_BITS;
    localparam int G2_SH = (2*R > QF) ? 2*R - QF : 0;
    localparam int GS_SH = (2*R > QF) ? QF : 2*R;
    localparam int HBW   = 46 - R;
    localparam int H     = (HBW + 1) / 2;
    localparam int MW    = (62 - 2*R > 31) ? 62 - 2*R : 31;
    localparam int VW    = MW + 2;
    localparam int SQI   = ((VW + 30) / 2) * 2;
    localparam int SQO   = SQI / 2;
    localparam int XW    = ((HBW > SQO) ? HBW : SQO) + 2;
    localparam logic signed [XW-1:0] P_ONE = XW'(ONE_Q);
    localparam logic signed [XW-1:0] N_ONE = -P_ONE;

    // stage 1: squares
    logic [30:0] ac;
    logic [61:0] r_pc2;
    logic [31:0] r_m2;
    logic [15:0] r_m1;
    logic        r_v1;
    // stage 2: c^2, s^2
    logic [30:0] r_c2_2;
    logic [30:0] r_s2;
    logic [15:0] r_m2b;
    logic [31:0] r_g2e;
    logic        r_v2;
    // stage 3: products with s^2
    logic [46:0] r_phb;
    logic [62:0] r_pgs;
    logic [30:0] r_c2_3;
    logic        r_v3;
    // stage 4: hb and constant term
    logic [HBW-1:0]       r_hb4;
    logic signed [VW-1:0] r_cc4;
    logic                 r_v4;
    // stage 5: partial products of hb^2
    logic [2*H-1:0]       r_pll;
    logic [HBW-1:0]       r_plh;
    logic [2*(HBW-H)-1:0] r_phh;
    logic [HBW-1:0]       r_hb5;
    logic signed [VW-1:0] r_cc5;
    logic                 r_v5;
    // stage 6: hb^2
    logic [2*HBW-1:0]     hb2f;
    logic signed [VW-1:0] r_hb2;
    logic [HBW-1:0]       r_hb6;
    logic signed [VW-1:0] r_cc6;
    logic                 r_v6;
    // stage 7: discriminant
    logic signed [VW-1:0] qd;
    logic [SQI-1:0]       r_rad;
    logic [HBW:0]         r_sb7;
    logic                 r_v7;
    // square root
    logic                 sq_v;
    logic [SQO-1:0]       sq_root;
    logic [HBW:0]         sq_sb;
    // stage 8: candidates
    logic signed [XW-1:0] r_x0;
    logic signed [XW-1:0] r_x1;
    logic                 r_neg8;
    logic                 r_v8;
    // stage 9: range test
    logic signed [31:0]   r_xo0;
    logic signed [31:0]   r_xo1;
    logic                 r_in0;
    logic                 r_in1;
    logic                 r_neg9;
    logic                 r_v9;

    assign ac   = i_cos[31] ? 31'(-i_cos) : i_cos[30:0];
    assign hb2f = ((2*HBW)'(r_phh) << (2*H)) + ((2*HBW)'(r_plh) << (H + 1))
                + (2*HBW)'(r_pll);
    assign qd   = r_hb2 - r_cc6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc2  <= 62'(ac) * 62'(ac);
            r_m2   <= 32'(i_mass_ratio) * 32'(i_mass_ratio);
            r_m1   <= i_mass_ratio;

            r_c2_2 <= r_pc2[QF+30:QF];
            r_s2   <= ONE_Q[30:0] - r_pc2[QF+30:QF];
            r_m2b  <= r_m1;
            r_g2e  <= r_m2 >> G2_SH;

            r_phb  <= 47'(r_m2b) * 47'(r_s2);
            r_pgs  <= 63'(r_g2e) * 63'(r_s2);
            r_c2_3 <= r_c2_2;

            r_hb4  <= HBW'(r_phb >> R);
            r_cc4  <= VW'(r_pgs >> GS_SH) - VW'(r_c2_3);

            r_pll  <= (2*H)'(r_hb4[H-1:0]) * (2*H)'(r_hb4[H-1:0]);
            r_plh  <= HBW'(r_hb4[HBW-1:H]) * HBW'(r_hb4[H-1:0]);
            r_phh  <= (2*(HBW-H))'(r_hb4[HBW-1:H]) * (2*(HBW-H))'(r_hb4[HBW-1:H]);
            r_hb5  <= r_hb4;
            r_cc5  <= r_cc4;

            r_hb2  <= VW'(hb2f >> QF);
            r_hb6  <= r_hb5;
            r_cc6  <= r_cc5;

            // negative discriminant: feed zero, flag it
            r_rad  <= qd[VW-1] ? '0 : SQI'({qd[VW-2:0], {QF{1'b0}}});
            r_sb7  <= {qd[VW-1], r_hb6};

            r_x0   <= XW'(sq_root) - XW'(sq_sb[HBW-1:0]);
            r_x1   <= -XW'(sq_root) - XW'(sq_sb[HBW-1:0]);
            r_neg8 <= sq_sb[HBW];

            r_xo0  <= r_x0[31:0];
            r_xo1  <= r_x1[31:0];
            r_in0  <= (r_x0 >= N_ONE) && (r_x0 <= P_ONE);
            r_in1  <= (r_x1 >= N_ONE) && (r_x1 <= P_ONE);
            r_neg9 <= r_neg8;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= sq_v;
            r_v9 <= r_v8;
        end
    end

    lcsa_sqrt #(
        .IW  (SQI),
        .SBW (HBW + 1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v7),
        .i_rad   (r_rad),
        .i_sb    (r_sb7),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    assign o_valid    = r_v9;
    assign o_neg_disc = r_neg9;
    assign o_in0      = r_in0;
    assign o_in1      = r_in1;
    assign o_x0       = r_xo0;
    assign o_x1       = r_xo1;
endmodule

// ===== hw/rtl/lcsa_acos.sv =====
// ============================================================================
// lcsa_acos: pipelined arc cosine to binary angle units
// sqrt(1-c^2), vectoring CORDIC, clamp, divide by pi through a reciprocal.
// ============================================================================
module lcsa_acos import lcsa_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int SBW             = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_c,
    input  logic [SBW-1:0]     i_sb,
    output logic               o_valid,
    output logic [15:0]        o_cm_angle,
    output logic [SBW-1:0]     o_sb
);
    localparam int N  = CORDIC_STAGES;
    localparam int QW = ANGLE_FRAC_BITS + 1;
    localparam int DW = ANGLE_FRAC_BITS + 33;
    localparam int SW = (QW > 16) ? QW : 16;
    localparam logic signed [CW-1:0] PI_C = CW'(PI_Q30);
    localparam logic [QW-1:0] PI_RCP =
        QW'((64'd1 << (32 + ANGLE_FRAC_BITS)) / 64'(PI_Q30));
    localparam logic [DW-1:0] PI_D  = DW'(PI_Q30);
    localparam logic [DW-1:0] PI2_D = DW'(PI_Q30) << 1;

    // stage 1 / 2: c^2 and the radicand
    logic [30:0]        ac;
    logic [61:0]        r_p;
    logic signed [31:0] r_c1;
    logic [SBW-1:0]     r_sb1;
    logic               r_v1;
    logic [61:0]        r_rad;
    logic [SBW+31:0]    r_sb2;
    logic               r_v2;
    logic               sq_v;
    logic [30:0]        sq_root;
    logic [SBW+31:0]    sq_sb;
    logic signed [31:0] c_s;

    logic signed [CW-1:0] r_x  [N+1];
    logic signed [CW-1:0] r_y  [N+1];
    logic signed [CW-1:0] r_z  [N+1];
    logic [SBW-1:0]       r_sb [N+1];
    logic                 r_v  [N+1];

    logic signed [CW-1:0] z_cl;
    logic [31:0]          r_zc;
    logic [SBW-1:0]       r_sbc;
    logic                 r_vc;

    logic [31+QW:0] qprod;
    logic [QW-1:0]  r_qe1;
    logic [DW-1:0]  r_num1;
    logic [SBW-1:0] r_dsb1;
    logic           r_dv1;
    logic [QW-1:0]  r_qe2;
    logic [DW-1:0]  r_num2;
    logic [DW-1:0]  r_qp2;
    logic [SBW-1:0] r_dsb2;
    logic           r_dv2;
    logic [QW-1:0]  r_qe3;
    logic [DW-1:0]  r_rm3;
    logic [SBW-1:0] r_dsb3;
    logic           r_dv3;

    logic [SW-1:0]  qx;
    logic [15:0]    r_cm;
    logic [SBW-1:0] r_sbo;
    logic           r_vo;

    assign ac  = i_c[31] ? 31'(-i_c) : i_c[30:0];
    assign c_s = sq_sb[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= 62'(ac) * 62'(ac);
            r_c1  <= i_c;
            r_sb1 <= i_sb;
            r_rad <= {1'b0, ONE_Q[30:0] - r_p[QF+30:QF], {QF{1'b0}}};
            r_sb2 <= {r_sb1, r_c1};
            // pre-rotate by pi/2 for a negative cosine
            if (c_s[31]) begin
                r_x[0] <= CW'(sq_root);
                r_y[0] <= -CW'(c_s);
                r_z[0] <= CW'(HALF_PI_Q30);
            end else begin
                r_x[0] <= CW'(c_s);
                r_y[0] <= CW'(sq_root);
                r_z[0] <= '0;
            end
            r_sb[0] <= sq_sb[SBW+31:32];
        end
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_v[0] <= sq_v;
        end
    end

    lcsa_sqrt #(
        .IW  (62),
        .SBW (SBW + 32)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v2),
        .i_rad   (r_rad),
        .i_sb    (r_sb2),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [CW-1:0] AT = CW'(ATAN_Q30[i]);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + AT;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - AT;
                end
                r_sb[i+1] <= r_sb[i];
            end
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    // clamp the angle to [0, pi]
    always_comb begin
        z_cl = r_z[N];
        if (z_cl < 0) begin
            z_cl = '0;
        end else if (z_cl > PI_C) begin
            z_cl = PI_C;
        end
    end

    // estimate the quotient from a reciprocal of pi; it falls short by at most two
    assign qprod = (32+QW)'(r_zc) * (32+QW)'(PI_RCP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zc   <= z_cl[31:0];
            r_sbc  <= r_sb[N];
            r_qe1  <= qprod[31+QW:32];
            r_num1 <= (DW'(r_zc) << ANGLE_FRAC_BITS) + DW'(PI_Q30 >> 1);
            r_dsb1 <= r_sbc;
            r_qe2  <= r_qe1;
            r_num2 <= r_num1;
            r_qp2  <= DW'(r_qe1) * PI_D;
            r_dsb2 <= r_dsb1;
            r_qe3  <= r_qe2;
            r_rm3  <= r_num2 - r_qp2;
            r_dsb3 <= r_dsb2;
        end
        if (!i_rst_n) begin
            r_vc  <= 1'b0;
            r_dv1 <= 1'b0;
            r_dv2 <= 1'b0;
            r_dv3 <= 1'b0;
        end else if (i_en) begin
            r_vc  <= r_v[N];
            r_dv1 <= r_vc;
            r_dv2 <= r_dv1;
            r_dv3 <= r_dv2;
        end
    end

    // add back the one or two divisors still held in the remainder
    assign qx = SW'(r_qe3) + SW'(r_rm3 >= PI_D) + SW'(r_rm3 >= PI2_D);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cm  <= (qx > SW'(CM_ANGLE_MAX)) ? CM_ANGLE_MAX : qx[15:0];
            r_sbo <= r_dsb3;
        end
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_dv3;
        end
    end

    assign o_valid    = r_vo;
    assign o_cm_angle = r_cm;
    assign o_sb       = r_sbo;
endmodule

// ===== hw/rtl/lab_to_cm_scatter_angle.sv =====
// ============================================================================
// lab_to_cm_scatter_angle: lab to centre-of-mass angle, two-body scattering
// Streams lab angles in, emits one or two CM angle solutions per angle.
// ============================================================================
// Use:
//   i_in carries one lab angle word (units of pi/2^15). o_out carries result
//   words {cm_angle, status, last}; last marks the final word of an angle.
//   An angle yields two words when both roots of the quadratic lie in
//   [-1, 1] (larger root first), one word otherwise; an error word carries
//   status 1 (negative discriminant) or 2 (no root in range) and angle 0.
//   i_cfg_we / i_cfg_wdata write the Q4.12 mass ratio; write it only while
//   the pipeline is empty. Reset value is 1.0.
// Pipeline:
//   From accept to the first result word an angle passes the cosine CORDIC,
//   the quadratic stage with its 35-bit square root, the arc cosine path
//   (31-bit square root, vectoring CORDIC, reciprocal division by pi) and
//   the output queue. One angle is accepted per cycle unless the output
//   queue holds the pipeline; angles with two solutions yield two words, so
//   the sustained rate is one result word per cycle while the receiver is ready.
// Reset and stall:
//   Reset empties every stage and the output queue. When the receiver holds
//   ready low, the four-word output queue fills and then the whole pipeline
//   holds; nothing is dropped or repeated.
// ============================================================================
module lab_to_cm_scatter_angle import lcsa_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    lcsa_in_if.sink           i_in,
    lcsa_out_if.source        o_out
);
    logic [15:0] r_mass_ratio;

    // global pipeline advance
    logic en;

    logic               cos_v;
    logic signed [31:0] cos_c;

    logic               q_v;
    logic               q_neg;
    logic               q_in0;
    logic               q_in1;
    logic signed [31:0] q_x0;
    logic signed [31:0] q_x1;

    logic        a0_v;
    logic        a1_v;
    logic [15:0] a0_cm;
    logic [15:0] a1_cm;
    t_root_flags a0_fl;
    logic        a1_in1;

    logic        ve;
    logic        two;
    t_result     e0;
    t_result     e1;
    logic        pop;
    logic        push;

    t_result     r_fifo [4];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [2:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_ratio <= MASS_RATIO_RST;
        end else if (i_cfg_we) begin
            r_mass_ratio <= i_cfg_wdata;
        end
    end

    lcsa_cos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_cos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in.valid),
        .i_lab_angle (i_in.lab_angle),
        .o_valid     (cos_v),
        .o_cos       (cos_c)
    );

    lcsa_quad #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_quad (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (cos_v),
        .i_cos        (cos_c),
        .i_mass_ratio (r_mass_ratio),
        .o_valid      (q_v),
        .o_neg_disc   (q_neg),
        .o_in0        (q_in0),
        .o_in1        (q_in1),
        .o_x0         (q_x0),
        .o_x1         (q_x1)
    );

    // larger root; also carries the discriminant flag and its own range flag
    lcsa_acos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES),
        .SBW             ($bits(t_root_flags))
    ) u_acos0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (q_v),
        .i_c        (q_x0),
        .i_sb       ({q_neg, q_in0}),
        .o_valid    (a0_v),
        .o_cm_angle (a0_cm),
        .o_sb       (a0_fl)
    );

    // smaller root
    lcsa_acos #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES),
        .SBW             (1)
    ) u_acos1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (q_v),
        .i_c        (q_x1),
        .i_sb       (q_in1),
        .o_valid    (a1_v),
        .o_cm_angle (a1_cm),
        .o_sb       (a1_in1)
    );

    // build the one or two result words of the angle leaving the pipeline
    always_comb begin
        ve  = a0_v & a1_v;
        two = 1'b0;
        e0  = '{cm_angle: '0, status: ST_NO_ROOT, last: 1'b1};
        e1  = '{cm_angle: a1_cm, status: ST_OK, last: 1'b1};
        priority if (a0_fl.neg_disc) begin
            e0 = '{cm_angle: '0, status: ST_NEG_DISC, last: 1'b1};
        end else if (a0_fl.in0 && a1_in1) begin
            e0  = '{cm_angle: a0_cm, status: ST_OK, last: 1'b0};
            two = 1'b1;
        end else if (a0_fl.in0) begin
            e0 = '{cm_angle: a0_cm, status: ST_OK, last: 1'b1};
        end else if (a1_in1) begin
            e0 = '{cm_angle: a1_cm, status: ST_OK, last: 1'b1};
        end else begin
            e0 = '{cm_angle: '0, status: ST_NO_ROOT, last: 1'b1};
        end
    end

    // advance unless the exiting angle would overflow the queue
    assign pop  = (r_cnt != 3'd0) && o_out.ready;
    assign en   = !ve || (r_cnt < 3'd3) || ((r_cnt == 3'd3) && pop);
    assign push = ve && en;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= e0;
            if (two) begin
                r_fifo[r_wp + 2'd1] <= e1;
            end
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + (two ? 2'd2 : 2'd1);
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + (push ? (two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign i_in.ready     = en;
    assign o_out.valid    = r_cnt != 3'd0;
    assign o_out.cm_angle = r_fifo[r_rp].cm_angle;
    assign o_out.status   = r_fifo[r_rp].status;
    assign o_out.last     = r_fifo[r_rp].last;
endmodule

// ===== tb/sv/lab_to_cm_scatter_angle_test.sv =====
// ============================================================================
// lab_to_cm_scatter_angle_test: self-checking bench of the lab to CM converter
// Streams lab angles under several mass ratios with random sender gaps and
// receiver stalls. A bit-exact fixed-point model in this file predicts every
// result word, and a checker compares each word in order.
// ============================================================================
module lab_to_cm_scatter_angle_test import lcsa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE      = 64'sd1 << 30;
    localparam longint SAT_MAX  = 64'sd1 << 47;
    localparam int     DRAIN    = 200;   // beyond the pipeline latency
    localparam int     IDLE_MAX = 5000;  // cycles with no word moved

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    lcsa_in_if  in_ch ();
    lcsa_out_if out_ch ();

    lab_to_cm_scatter_angle dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Mass ratio as the model sees it, and the queue of words still due
    logic [15:0] cur_ratio;
    t_result     due_words[$];
    int          errors;
    int          ready_stall_pct;
    int          hold_off_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Fixed-point model of the converter
    // ------------------------------------------------------------------
    function automatic longint clip47(longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < -SAT_MAX) return -SAT_MAX;
        return v;
    endfunction

    // Q30 product, magnitude truncated, saturated to 2^47
    function automatic longint q30_mul(longint a, longint b);
        bit           neg;
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] r;
        neg = (a < 0) != (b < 0);
        ua  = {64'd0, (a < 0) ? -a : a};
        ub  = {64'd0, (b < 0) ? -b : b};
        r   = (ua * ub) >> 30;
        if (r > 128'(SAT_MAX)) r = 128'(SAT_MAX);
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    // floor(sqrt(v * 2^30))
    function automatic longint q30_sqrt(longint v);
        logic [127:0] target;
        logic [127:0] r;
        logic [127:0] t;
        if (v <= 0) return 0;
        target = {64'd0, v} << 30;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= target) r = t;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic longint atan_step(int i);
        return longint'({32'd0, ATAN_Q30[i]});
    endfunction

    function automatic longint lab_cos(logic [15:0] ang);
        longint a;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     neg;
        a = longint'({48'd0, ang});
        neg = 1'b0;
        if (a > 32768) a = 65536 - a;
        if (a > 16384) begin
            a = 32768 - a;
            neg = 1'b1;
        end
        z = (a * longint'({32'd0, PI_Q30}) + 16384) >>> 15;
        x = longint'({32'd0, K_Q30});
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end else begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
        end
        if (x < 0) x = 0;
        if (x > ONE) x = ONE;
        return neg ? -x : x;
    endfunction

    function automatic logic [15:0] cm_arccos(longint c);
        longint x;
        longint y;
        longint z;
        longint t;
        longint rem;
        longint xs;
        longint ys;
        logic [63:0] u;
        x = c;
        z = 0;
        rem = ONE - q30_mul(c, c);
        if (rem < 0) rem = 0;
        y = q30_sqrt(rem);
        if (x < 0) begin
            t = x; x = y; y = -t; z = longint'({32'd0, HALF_PI_Q30});
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end else begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'({32'd0, PI_Q30})) z = longint'({32'd0, PI_Q30});
        u = ((64'(z) << 15) + (64'(PI_Q30) >> 1)) / 64'(PI_Q30);
        return (u > 64'hFFFF) ? CM_ANGLE_MAX : u[15:0];
    endfunction

    // Work out the words one lab angle yields and queue them
    task automatic predict_cm_words(logic [15:0] ang);
        longint  c;
        longint  c2;
        longint  s2;
        longint  g;
        longint  hb;
        longint  g2;
        longint  cc;
        longint  qd;
        longint  r;
        longint  root[2];
        int      n;
        t_result w;
        c  = lab_cos(ang);
        c2 = q30_mul(c, c);
        s2 = ONE - c2;
        if (s2 < 0) s2 = 0;
        g  = longint'({48'd0, cur_ratio}) << 18;
        hb = q30_mul(g, s2);
        g2 = q30_mul(g, g);
        cc = clip47(q30_mul(g2, s2) - c2);
        qd = clip47(q30_mul(hb, hb) - cc);
        if (qd < 0) begin
            w.cm_angle = '0; w.status = ST_NEG_DISC; w.last = 1'b1;
            due_words = {due_words, w};
            return;
        end
        r = q30_sqrt(qd);
        root[0] = clip47(-hb + r);
        root[1] = clip47(-hb - r);
        n = 0;
        for (int k = 0; k < 2; k++) begin
            if (root[k] >= -ONE && root[k] <= ONE) begin
                w.cm_angle = cm_arccos(root[k]); w.status = ST_OK; w.last = 1'b0;
                due_words = {due_words, w};
                n++;
            end
        end
        if (n == 0) begin
            w.cm_angle = '0; w.status = ST_NO_ROOT; w.last = 1'b1;
            due_words = {due_words, w};
        end else begin
            due_words[$].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one angle from a falling edge and hold it until accepted.
    // Valid stays high on return so back-to-back words need no toggle.
    task automatic send_angle(logic [15:0] ang);
        in_ch.valid     = 1'b1;
        in_ch.lab_angle = ang;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_cm_words(ang);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int cycles);
        in_ch.valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Wait for every due word, let the pipe settle, then load a new ratio
    task automatic load_ratio(logic [15:0] ratio);
        idle_sender(1);
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = ratio;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cur_ratio   = ratio;
    endtask

    // Random angle: mostly in [0, pi], sometimes any 16-bit code
    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(32760, 32768));
            2:       return 16'($urandom_range(0, 8));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Bursts of random length, random gaps between them
    task automatic send_random_bursts(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) send_angle(random_angle());
            left -= burst;
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_edge_angles();
        logic [15:0] edge_angles[12];
        edge_angles = '{16'd0, 16'd1, 16'd8192, 16'd16383, 16'd16384, 16'd16385,
                        16'd24576, 16'd32767, 16'd32768, 16'd32769, 16'd49152,
                        16'hFFFF};
        foreach (edge_angles[i]) send_angle(edge_angles[i]);
    endtask

    // Ratio zero, just below one, two, and the largest code
    task automatic test_ratio_extremes();
        logic [15:0] ratios[4];
        ratios = '{16'd0, 16'd4095, 16'd8192, 16'hFFFF};
        foreach (ratios[i]) begin
            load_ratio(ratios[i]);
            send_angle(16'd0);
            send_angle(16'd10923);
            send_angle(16'd16384);
            send_angle(16'd32768);
        end
    endtask

    task automatic test_random_ratios();
        logic [15:0] ratio;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0:       ratio = 16'($urandom_range(0, 4096));
                1:       ratio = 16'($urandom_range(4096, 12288));
                default: ratio = 16'($urandom);
            endcase
            load_ratio(ratio);
            ready_stall_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
            send_random_bursts(30);
        end
        ready_stall_pct = 25;
    endtask

    // Hold the receiver off long enough to fill the pipe and stall the
    // input, keep offering words all the while
    task automatic test_output_hold_off();
        load_ratio(16'd6144);
        hold_off_cycles = 400;
        repeat (160) send_angle(random_angle());
        idle_sender(1);
        // Pause until every due word has arrived, then resume back to back
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (20) send_angle(random_angle());
        idle_sender(1);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word cm_angle=%0d status=%0d last=%0b",
                         $time, out_ch.cm_angle, out_ch.status, out_ch.last);
                errors++;
            end else begin
                exp_w = due_words.pop_front();
                if (out_ch.cm_angle !== exp_w.cm_angle || out_ch.status !== exp_w.status
                        || out_ch.last !== exp_w.last) begin
                    $display("%0t: mismatch expected cm_angle=%0d status=%0d last=%0b",
                             $time, exp_w.cm_angle, exp_w.status, exp_w.last);
                    $display("%0t:          actual   cm_angle=%0d status=%0d last=%0b",
                             $time, out_ch.cm_angle, out_ch.status, out_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        int idle_count;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= IDLE_MAX) begin
                $display("FAIL lab_to_cm_scatter_angle");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        errors          = 0;
        cur_ratio       = MASS_RATIO_RST;
        ready_stall_pct = 0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.lab_angle = '0;
        out_ch.ready    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_angles();
        test_ratio_extremes();
        test_random_ratios();
        test_output_hold_off();
        load_ratio(MASS_RATIO_RST);
        send_random_bursts(20);

        idle_sender(1);
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS lab_to_cm_scatter_angle");
        end else begin
            $display("FAIL lab_to_cm_scatter_angle");
        end
        $finish;
    end

endmodule
